/* rtl/midi_track_event_parser_top_assert.svh */
`ifndef MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH
`define MIDI_TRACK_EVENT_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define MTEP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mtep assertion failed");

// next-cycle implication
`define MTEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mtep assertion failed");

`endif

/* rtl/mtep_pkg.sv */
package mtep_pkg;

   localparam logic [2:0] KIND_NOTE    = 3'd0;
   localparam logic [2:0] KIND_PROGRAM = 3'd1;
   localparam logic [2:0] KIND_TEMPO   = 3'd2;
   localparam logic [2:0] KIND_EOT     = 3'd3;
   localparam logic [2:0] KIND_NO_STAT = 3'd4;

   localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
   localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
   localparam logic [3:0] NIB_PROGRAM  = 4'hc;
   localparam logic [3:0] NIB_PRESSURE = 4'hd;

   localparam logic [7:0]  ST_CHAN_MAX = 8'hef;
   localparam logic [7:0]  ST_SYSEX    = 8'hf0;
   localparam logic [7:0]  ST_SYSEX_C  = 8'hf7;
   localparam logic [7:0]  ST_META     = 8'hff;
   localparam logic [7:0]  META_EOT    = 8'h2f;
   localparam logic [7:0]  META_TEMPO  = 8'h51;
   localparam logic [23:0] TEMPO_INIT  = 24'd500000;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  status;
      logic [7:0]  data_a;
      logic [7:0]  data_b;
      logic [23:0] tempo;
      logic [31:0] tick;
   } mtep_event_type;

   typedef struct packed {
      logic full;
      logic empty;
   } mtep_q_status_type;

   typedef struct packed {
      logic [2:0]  event_kind;
      logic [3:0]  channel;
      logic [6:0]  key;
      logic [7:0]  value;
      logic [23:0] tempo_us;
      logic [31:0] tick;
   } mtep_rsp_type;

endpackage

/* rtl/mtep_if.sv */
interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] track_byte;
   logic       new_track;

   modport source (output valid, output track_byte, output new_track, input ready);
   modport sink   (input valid, input track_byte, input new_track, output ready);
endinterface

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_kind;
   logic [3:0]  channel;
   logic [6:0]  key;
   logic [7:0]  value;
   logic [23:0] tempo_us;
   logic [31:0] tick;

   modport source (output valid, output event_kind, output channel, output key,
                   output value, output tempo_us, output tick, input ready);
   modport sink   (input valid, input event_kind, input channel, input key,
                   input value, input tempo_us, input tick, output ready);
endinterface

/* rtl/mtep_front.sv */
`include "midi_track_event_parser_top_assert.svh"

module mtep_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              track_byte,
   input  logic                    new_track,
   output logic                    emit,
   output mtep_pkg::mtep_event_type evt
);
   import mtep_pkg::*;

   localparam logic [3:0] PH_DELTA  = 4'd0;
   localparam logic [3:0] PH_STATUS = 4'd1;
   localparam logic [3:0] PH_KEY    = 4'd2;
   localparam logic [3:0] PH_VEL    = 4'd3;
   localparam logic [3:0] PH_PROG   = 4'd4;
   localparam logic [3:0] PH_SKIP   = 4'd5;
   localparam logic [3:0] PH_SYSLEN = 4'd6;
   localparam logic [3:0] PH_MTYPE  = 4'd7;
   localparam logic [3:0] PH_MLEN   = 4'd8;
   localparam logic [3:0] PH_TEMPO  = 4'd9;

   logic [3:0]  phase_ff,  phase_in;
   logic [7:0]  status_ff, status_in;
   logic [31:0] tick_ff,   tick_in;
   logic [31:0] accum_ff,  accum_in;
   logic [7:0]  first_ff,  first_in;
   logic [7:0]  meta_ff,   meta_in;
   logic [31:0] left_ff,   left_in;
   logic [23:0] tempo_ff,  tempo_in;
   logic        done_ff,   done_in;

   logic [3:0]  cur_phase;
   logic [7:0]  cur_status;
   logic [31:0] cur_tick;
   logic [31:0] cur_accum;
   logic [7:0]  cur_first;
   logic [7:0]  cur_meta;
   logic [31:0] cur_left;
   logic [23:0] cur_tempo;
   logic        cur_done;
   logic [3:0]  work_phase;
   logic [31:0] work_left;
   logic [31:0] left_dec;
   logic [31:0] vlq;

   always_comb begin
      cur_phase  = new_track ? PH_DELTA   : phase_ff;
      cur_status = new_track ? 8'h00      : status_ff;
      cur_tick   = new_track ? 32'h0      : tick_ff;
      cur_accum  = new_track ? 32'h0      : accum_ff;
      cur_first  = new_track ? 8'h00      : first_ff;
      cur_meta   = new_track ? 8'h00      : meta_ff;
      cur_left   = new_track ? 32'h0      : left_ff;
      cur_tempo  = new_track ? TEMPO_INIT : tempo_ff;
      cur_done   = new_track ? 1'b0       : done_ff;

      phase_in  = cur_phase;
      status_in = cur_status;
      tick_in   = cur_tick;
      accum_in  = cur_accum;
      first_in  = cur_first;
      meta_in   = cur_meta;
      left_in   = cur_left;
      tempo_in  = cur_tempo;
      done_in   = cur_done;

      emit       = 1'b0;
      evt        = '0;
      evt.status = cur_status;
      evt.data_a = cur_first;
      evt.data_b = track_byte;
      evt.tick   = cur_tick;

      // running status: data byte enters the phase of the held status
      work_phase = cur_phase;
      work_left  = cur_left;
      if (cur_phase == PH_STATUS && !track_byte[7] && cur_status[7]) begin
         unique case (cur_status[7:4]) inside
            NIB_NOTE_OFF, NIB_NOTE_ON: work_phase = PH_KEY;
            NIB_PROGRAM:               work_phase = PH_PROG;
            NIB_PRESSURE: begin
               work_phase = PH_SKIP;
               work_left  = 32'd1;
            end
            default: begin
               work_phase = PH_SKIP;
               work_left  = 32'd2;
            end
         endcase
      end

      left_dec = work_left - 32'd1;
      vlq      = {cur_left[24:0], track_byte[6:0]};

      if (!cur_done) begin
         unique case (work_phase)
            PH_DELTA: begin
               accum_in = {cur_accum[24:0], track_byte[6:0]};
               if (!track_byte[7]) begin
                  tick_in  = cur_tick + accum_in;
                  accum_in = 32'h0;
                  phase_in = PH_STATUS;
               end
            end
            PH_STATUS: begin
               if (!track_byte[7]) begin
                  // no running status: flag, then byte is a one-byte delta
                  emit     = 1'b1;
                  evt.kind = KIND_NO_STAT;
                  tick_in  = cur_tick + {25'h0, track_byte[6:0]};
                  phase_in = PH_STATUS;
               end else if (track_byte <= ST_CHAN_MAX) begin
                  status_in = track_byte;
                  unique case (track_byte[7:4]) inside
                     NIB_NOTE_OFF, NIB_NOTE_ON: phase_in = PH_KEY;
                     NIB_PROGRAM:               phase_in = PH_PROG;
                     NIB_PRESSURE: begin
                        phase_in = PH_SKIP;
                        left_in  = 32'd1;
                     end
                     default: begin
                        phase_in = PH_SKIP;
                        left_in  = 32'd2;
                     end
                  endcase
               end else if (track_byte == ST_SYSEX || track_byte == ST_SYSEX_C) begin
                  left_in  = 32'h0;
                  phase_in = PH_SYSLEN;
               end else if (track_byte == ST_META) begin
                  phase_in = PH_MTYPE;
               end else begin
                  phase_in = PH_DELTA;
               end
            end
            PH_KEY: begin
               first_in = track_byte;
               phase_in = PH_VEL;
            end
            PH_VEL: begin
               phase_in = PH_DELTA;
               emit     = 1'b1;
               evt.kind = KIND_NOTE;
            end
            PH_PROG: begin
               phase_in = PH_DELTA;
               emit     = 1'b1;
               evt.kind = KIND_PROGRAM;
            end
            PH_SKIP: begin
               left_in  = left_dec;
               phase_in = (left_dec == 32'h0) ? PH_DELTA : PH_SKIP;
            end
            PH_SYSLEN: begin
               left_in = vlq;
               if (!track_byte[7]) begin
                  phase_in = (vlq == 32'h0) ? PH_DELTA : PH_SKIP;
               end
            end
            PH_MTYPE: begin
               meta_in  = track_byte;
               left_in  = 32'h0;
               phase_in = PH_MLEN;
            end
            PH_MLEN: begin
               left_in = vlq;
               if (!track_byte[7]) begin
                  if (cur_meta == META_EOT && vlq == 32'h0) begin
                     done_in  = 1'b1;
                     phase_in = PH_DELTA;
                     emit     = 1'b1;
                     evt.kind = KIND_EOT;
                  end else if (cur_meta == META_TEMPO && vlq == 32'd3) begin
                     phase_in = PH_TEMPO;
                  end else begin
                     phase_in = (vlq == 32'h0) ? PH_DELTA : PH_SKIP;
                  end
               end
            end
            PH_TEMPO: begin
               tempo_in = {cur_tempo[15:0], track_byte};
               left_in  = left_dec;
               if (left_dec == 32'h0) begin
                  phase_in  = PH_DELTA;
                  emit      = 1'b1;
                  evt.kind  = KIND_TEMPO;
                  evt.tempo = tempo_in;
               end
            end
            default: phase_in = PH_DELTA;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_DELTA;
         status_ff <= 8'h00;
         tick_ff   <= 32'h0;
         accum_ff  <= 32'h0;
         first_ff  <= 8'h00;
         meta_ff   <= 8'h00;
         left_ff   <= 32'h0;
         tempo_ff  <= TEMPO_INIT;
         done_ff   <= 1'b0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         status_ff <= status_in;
         tick_ff   <= tick_in;
         accum_ff  <= accum_in;
         first_ff  <= first_in;
         meta_ff   <= meta_in;
         left_ff   <= left_in;
         tempo_ff  <= tempo_in;
         done_ff   <= done_in;
      end
   end

   `MTEP_ASSERT_NOW(a_done_silent, clock, reset, accept && done_ff && !new_track, !emit)
   `MTEP_ASSERT_NOW(a_status_accum_clear, clock, reset, phase_ff == PH_STATUS, accum_ff == 32'h0)

endmodule

/* rtl/mtep_queue.sv */
`include "midi_track_event_parser_top_assert.svh"

module mtep_queue #(
   parameter int DEPTH = 2
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mtep_pkg::mtep_event_type    push_data,
   input  logic                        pop,
   output mtep_pkg::mtep_event_type    head,
   output mtep_pkg::mtep_q_status_type status
);
   import mtep_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   mtep_event_type mem_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]  count_ff,  count_in;

   assign status.full  = (count_ff == CW'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MTEP_ASSERT_NOW(a_no_overflow, clock, reset, push, !status.full)
   `MTEP_ASSERT_NOW(a_no_underflow, clock, reset, pop, !status.empty)

endmodule

/* rtl/mtep_back.sv */
module mtep_back (
   input  logic                        clock,
   input  logic                        reset,
   input  mtep_pkg::mtep_event_type    head,
   input  mtep_pkg::mtep_q_status_type q_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output mtep_pkg::mtep_rsp_type      rsp
);
   import mtep_pkg::*;

   logic         valid_ff, valid_in;
   mtep_rsp_type rsp_ff,   rsp_in;

   assign pop = !q_status.empty && (!valid_ff || rsp_ready);

   always_comb begin
      rsp_in            = '0;
      rsp_in.event_kind = head.kind;
      rsp_in.tick       = head.tick;
      unique case (head.kind)
         KIND_NOTE: begin
            rsp_in.channel = head.status[3:0];
            rsp_in.key     = head.data_a[6:0];
            rsp_in.value   = (head.status[7:4] == NIB_NOTE_OFF) ? 8'h00 : head.data_b;
         end
         KIND_PROGRAM: begin
            rsp_in.channel = head.status[3:0];
            rsp_in.value   = head.data_b;
         end
         KIND_TEMPO:   rsp_in.tempo_us = head.tempo;
         default:      rsp_in.tempo_us = 24'h0;
      endcase

      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/midi_track_event_parser_top.sv */
// Byte-serial parser for the data of one standard MIDI file track. It takes one byte per
// clock cycle with no gaps of its own; the only stall comes from the event queue filling
// when the result side holds back. The parser state is updated at the byte's acceptance and
// an event is queued at the same edge; the event then moves into the output register, which
// raises rsp valid, once that register is empty or its response is being taken. QUEUE_DEPTH
// events can wait between parser and output register before the byte side stalls. Raise
// new_track with the first byte of each track.
module midi_track_event_parser_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   mtep_req_if.sink          req_bus,
   mtep_rsp_if.source        rsp_bus
);
   import mtep_pkg::*;

   logic              accept;
   logic              emit;
   logic              pop;
   mtep_event_type    evt;
   mtep_event_type    head;
   mtep_q_status_type q_status;
   mtep_rsp_type      rsp;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   mtep_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .track_byte (req_bus.track_byte),
      .new_track  (req_bus.new_track),
      .emit       (emit),
      .evt        (evt)
   );

   mtep_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && emit),
      .push_data (evt),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   mtep_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp       (rsp)
   );

   assign rsp_bus.event_kind = rsp.event_kind;
   assign rsp_bus.channel    = rsp.channel;
   assign rsp_bus.key        = rsp.key;
   assign rsp_bus.value      = rsp.value;
   assign rsp_bus.tempo_us   = rsp.tempo_us;
   assign rsp_bus.tick       = rsp.tick;

endmodule
